/* hdl/ibip_pkg.sv */
// shared constants, types and threshold function for the inode block map
package ibip_pkg;

   // inode layout
   localparam int unsigned DIRECT_SLOTS   = 12;

   // pointers per indirect block, log2
   localparam int unsigned LOG2_W         = 4;
   localparam logic [LOG2_W-1:0] PTR_LOG2_MIN   = 4'd4;
   localparam logic [LOG2_W-1:0] PTR_LOG2_MAX   = 4'd12;
   localparam logic [LOG2_W-1:0] PTR_LOG2_RESET = 4'd8;

   // field widths
   localparam int unsigned BLOCK_W  = 32;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned DEPTH_W  = 2;
   localparam int unsigned OFFSET_W = 12;

   // remainder inside the triple tree stays below 2^(3*12)
   localparam int unsigned REM_W    = 3 * OFFSET_W;
   // sums of all tree reaches plus direct slots, with a sign bit on top
   localparam int unsigned SUM_W    = REM_W + 2;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_PTR_LOG2 = 1'b0;

   // indirection depths
   localparam logic [DEPTH_W-1:0] DEPTH_DIRECT = 2'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_SINGLE = 2'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_DOUBLE = 2'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_TRIPLE = 2'd3;

   // first block number past each region
   typedef struct packed {
      logic [SUM_W-1:0] end_direct;
      logic [SUM_W-1:0] end_single;
      logic [SUM_W-1:0] end_double;
      logic [SUM_W-1:0] end_triple;
   } bounds_type;

   // classified item between the two logic stages
   typedef struct packed {
      logic [REM_W-1:0]   remainder;
      logic [DEPTH_W-1:0] depth;
      logic [SLOT_W-1:0]  top_slot;
      logic               out_of_range;
      logic [LOG2_W-1:0]  log2;
   } class_type;

   // region bounds for a given pointers-per-block log2
   function automatic bounds_type region_bounds(input logic [LOG2_W-1:0] log2);
      logic [SUM_W-1:0] reach1;
      logic [SUM_W-1:0] reach2;
      logic [SUM_W-1:0] reach3;
      logic [LOG2_W+1:0] sh1;
      bounds_type b;
      sh1    = {2'b00, log2};
      reach1 = SUM_W'(1) << sh1;
      reach2 = SUM_W'(1) << (sh1 << 1);
      reach3 = SUM_W'(1) << (sh1 + (sh1 << 1));
      b.end_direct = SUM_W'(DIRECT_SLOTS);
      b.end_single = b.end_direct + reach1;
      b.end_double = b.end_single + reach2;
      b.end_triple = b.end_double + reach3;
      return b;
   endfunction

endpackage

/* hdl/inode_block_to_index_path_top.sv */
// inode block map: logical block number to inode slot, depth and offsets
// the rsp_valid strobe follows the start transfer through the input, classify and result registers
// throughput: one block number per cycle, busy stays low
// path: input register, region classify, register, offset extract, result register
// reset: synchronous active high, clears the pipeline valids and sets the log2 register to 8
// results are strobed for one cycle and cannot be held off by the receiver
module inode_block_to_index_path_top
   import ibip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [BLOCK_W-1:0]    req_block_number,
   // result channel
   output logic                  rsp_valid,
   output logic [SLOT_W-1:0]     rsp_top_slot,
   output logic [DEPTH_W-1:0]    rsp_depth,
   output logic [OFFSET_W-1:0]   rsp_first_offset,
   output logic [OFFSET_W-1:0]   rsp_second_offset,
   output logic [OFFSET_W-1:0]   rsp_third_offset,
   output logic                  rsp_out_of_range,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [LOG2_W-1:0]   ptr_log2_ff;
   logic [LOG2_W-1:0]   ptr_log2_in;
   logic [LOG2_W-1:0]   eff_log2;

   logic                s1_valid_ff;
   logic [BLOCK_W-1:0]  s1_block_ff;
   logic [LOG2_W-1:0]   s1_log2_ff;

   logic                s2_valid_ff;
   class_type           s2_ff;
   class_type           s2_in;

   logic [OFFSET_W-1:0] o1_in;
   logic [OFFSET_W-1:0] o2_in;
   logic [OFFSET_W-1:0] o3_in;

   bounds_type          bounds;
   logic [SUM_W-1:0]    block_ext;
   logic [SUM_W-1:0]    diff_direct;
   logic [SUM_W-1:0]    diff_single;
   logic [SUM_W-1:0]    diff_double;
   logic [SUM_W-1:0]    diff_triple;

   logic [REM_W-1:0]    rem_shift1;
   logic [REM_W-1:0]    rem_shift2;
   logic [OFFSET_W-1:0] offset_mask;
   logic                csr_write;

   // configuration register
   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      ptr_log2_in = ptr_log2_ff;
      if (csr_write && (paddr[2] == REG_PTR_LOG2)) begin
         ptr_log2_in = pwdata[LOG2_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PTR_LOG2) begin
         prdata = {{(CSR_DATA_W-LOG2_W){1'b0}}, ptr_log2_ff};
      end
   end

   // clamp the log2 to the supported block sizes
   always_comb begin
      eff_log2 = ptr_log2_ff;
      if (ptr_log2_ff < PTR_LOG2_MIN) begin
         eff_log2 = PTR_LOG2_MIN;
      end else if (ptr_log2_ff > PTR_LOG2_MAX) begin
         eff_log2 = PTR_LOG2_MAX;
      end
   end

   // classify region with parallel subtracts against the region bounds
   always_comb begin
      bounds      = region_bounds(s1_log2_ff);
      block_ext   = {{(SUM_W-BLOCK_W){1'b0}}, s1_block_ff};
      diff_direct = block_ext - bounds.end_direct;
      diff_single = block_ext - bounds.end_single;
      diff_double = block_ext - bounds.end_double;
      diff_triple = block_ext - bounds.end_triple;

      s2_in.log2         = s1_log2_ff;
      s2_in.remainder    = '0;
      s2_in.depth        = DEPTH_DIRECT;
      s2_in.top_slot     = '0;
      s2_in.out_of_range = 1'b0;
      if (diff_direct[SUM_W-1]) begin
         s2_in.top_slot = s1_block_ff[SLOT_W-1:0];
      end else if (diff_single[SUM_W-1]) begin
         s2_in.depth     = DEPTH_SINGLE;
         s2_in.remainder = diff_direct[REM_W-1:0];
         s2_in.top_slot  = SLOT_W'(DIRECT_SLOTS);
      end else if (diff_double[SUM_W-1]) begin
         s2_in.depth     = DEPTH_DOUBLE;
         s2_in.remainder = diff_single[REM_W-1:0];
         s2_in.top_slot  = SLOT_W'(DIRECT_SLOTS + 1);
      end else if (diff_triple[SUM_W-1]) begin
         s2_in.depth     = DEPTH_TRIPLE;
         s2_in.remainder = diff_double[REM_W-1:0];
         s2_in.top_slot  = SLOT_W'(DIRECT_SLOTS + 2);
      end else begin
         s2_in.out_of_range = 1'b1;
      end
   end

   // split the remainder into per-level offsets
   always_comb begin
      rem_shift1  = s2_ff.remainder >> s2_ff.log2;
      rem_shift2  = s2_ff.remainder >> ({1'b0, s2_ff.log2} << 1);
      offset_mask = OFFSET_W'((OFFSET_W+1)'(1) << s2_ff.log2) - OFFSET_W'(1);
      o1_in = '0;
      o2_in = '0;
      o3_in = '0;
      case (s2_ff.depth)
         DEPTH_DIRECT: begin
         end
         DEPTH_SINGLE: begin
            o1_in = s2_ff.remainder[OFFSET_W-1:0];
         end
         DEPTH_DOUBLE: begin
            o1_in = rem_shift1[OFFSET_W-1:0];
            o2_in = s2_ff.remainder[OFFSET_W-1:0] & offset_mask;
         end
         DEPTH_TRIPLE: begin
            o1_in = rem_shift2[OFFSET_W-1:0];
            o2_in = rem_shift1[OFFSET_W-1:0] & offset_mask;
            o3_in = s2_ff.remainder[OFFSET_W-1:0] & offset_mask;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_log2_ff <= PTR_LOG2_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         ptr_log2_ff <= ptr_log2_in;
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid   <= s2_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_block_ff       <= req_block_number;
      s1_log2_ff        <= eff_log2;
      s2_ff             <= s2_in;
      rsp_top_slot      <= s2_ff.top_slot;
      rsp_depth         <= s2_ff.depth;
      rsp_out_of_range  <= s2_ff.out_of_range;
      rsp_first_offset  <= o1_in;
      rsp_second_offset <= o2_in;
      rsp_third_offset  <= o3_in;
   end

`ifndef SYNTHESIS
   // every accepted command yields a result strobe
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |-> ##3 rsp_valid)
      else $error("result strobe missing after command");

   // out of range results carry no path
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
      (rsp_top_slot == '0 && rsp_depth == DEPTH_DIRECT && rsp_first_offset == '0 &&
       rsp_second_offset == '0 && rsp_third_offset == '0))
      else $error("out of range result with nonzero fields");

   // indirect results point at the matching tree slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range && rsp_depth != DEPTH_DIRECT) |->
      (rsp_top_slot == SLOT_W'(DIRECT_SLOTS) + SLOT_W'(rsp_depth) - SLOT_W'(1)))
      else $error("tree slot does not match depth");

   // offsets below the depth stay zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_depth != DEPTH_TRIPLE) |-> (rsp_third_offset == '0))
      else $error("third offset used above triple depth");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_depth == DEPTH_DIRECT || rsp_depth == DEPTH_SINGLE)) |->
      (rsp_second_offset == '0))
      else $error("second offset used in shallow path");
`endif

endmodule
